/* sv/brf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, codes and fixed-point helpers for the Brent root finder step.
// ----------------------------------------------------------------------------
package brf_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_EVAL       = 2'd0,
        ST_ROOT       = 2'd1,
        ST_NO_BRACKET = 2'd2,
        ST_NO_SEARCH  = 2'd3
    } status_t;

    // configuration register indexes
    localparam logic CFG_TOLERANCE    = 1'b0;
    localparam logic CFG_ZERO_EPSILON = 1'b1;

    // input kind carried in tuser
    localparam logic FUNC_START = 1'b0;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // divider request and response
    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } div_rsp_t;

    // saturate a 35-bit signed value to Q16.16
    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sh0_7FFF_FFFF) begin
            r = Q_MAX;
        end else if (v < -35'sh0_8000_0000) begin
            r = Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // raw product to Q16.16, truncated toward zero and saturated
    function automatic logic signed [31:0] q16_sat(input logic signed [63:0] p);
        logic signed [63:0] t;
        logic signed [31:0] r;
        t = p[63] ? ((p + 64'sd65535) >>> 16) : (p >>> 16);
        if (t > 64'sh7FFF_FFFF) begin
            r = Q_MAX;
        end else if (t < -64'sh8000_0000) begin
            r = Q_MIN;
        end else begin
            r = t[31:0];
        end
        return r;
    endfunction

    // magnitude of a 33-bit signed difference
    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

endpackage

/* sv/brent_root_finder_step.sv */
`timescale 1ns / 1ps
// A bad bracket or a value with no search goes straight from S_IDLE to S_OUT; a value that
// ends the search passes S_TOL, S_TOLW and S_CONV first; a secant step adds one division and
// one product, and an interpolation step 6 divisions plus 6 products, before S_SEL and S_OUT.
// Throughput: one item at a time; s_tready returns the cycle after the result
// transaction. The divider's 48-step one-bit-per-cycle loop sets the pace.
// Reset (aresetn low, synchronous) clears the search state; tolerance and epsilon go to 1.
// ----------------------------------------------------------------------------
// brent_root_finder_step
// Brent bracketing root search step, exchanging probe points and function
// values with an outside evaluator, in saturating Q16.16.
// ----------------------------------------------------------------------------
module brent_root_finder_step (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_addr,
    input  logic [30:0]  cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,  // start_a, start_b, start_fa, start_fb, probe_value
    input  logic [0:0]   s_tuser,  // func
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // point
    output logic [1:0]   m_tuser   // status
);

    typedef enum logic [3:0] {
        S_IDLE, S_TOL, S_TOLW, S_CONV, S_DIV, S_DIVW, S_MUL, S_MULW, S_SEL, S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic signed [31:0] fa_reg, fa_next, fb_reg, fb_next, fc_reg, fc_next;
    logic signed [31:0] probe_reg, probe_next, fs_reg, fs_next;
    logic               flag_reg, flag_next, srch_reg, srch_next;
    logic               vmode_reg, vmode_next, interp_reg, interp_next;
    logic [1:0]         term_reg, term_next;
    logic               phase_reg, phase_next;
    logic signed [31:0] divq_reg, divq_next, mtmp_reg, mtmp_next, scand_reg, scand_next;
    logic signed [33:0] acc_reg, acc_next;
    logic [30:0]        tol_reg, eps_reg;
    logic [61:0]        tol2_reg, tol2_next;
    brf_pkg::status_t   ost_reg, ost_next;
    logic signed [31:0] opt_reg, opt_next;

    brf_pkg::div_req_t  dreq;
    brf_pkg::div_rsp_t  drsp;
    logic               mul_en;
    logic signed [31:0] mul_x, mul_y;
    logic signed [63:0] prod;

    brf_div u_div (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));
    brf_mul u_mul (.aclk(aclk), .en(mul_en), .op_x(mul_x), .op_y(mul_y), .prod(prod));

    // input fields
    logic signed [31:0] in_a, in_b, in_fa, in_fb, in_fv;
    assign in_a  = s_tdata[31:0];
    assign in_b  = s_tdata[63:32];
    assign in_fa = s_tdata[95:64];
    assign in_fb = s_tdata[127:96];
    assign in_fv = s_tdata[159:128];

    // working values
    logic signed [32:0] d_fafb, d_fbfa, d_fafc, d_fcfa, d_fbfc, d_fcfb, d_ba, d_cd, d_bc, d_sb;
    logic signed [31:0] q_mul, mid;
    logic signed [32:0] sum_ab;
    logic signed [33:0] acc_sum;
    logic signed [34:0] q4, s4;
    logic               between, bis, fuzzy_ac, fuzzy_bc, conv_b, fuzzy_s;
    logic [32:0]        span_mag;
    logic [33:0]        sb2;
    logic               opp_in, swap;
    logic signed [31:0] pa, pb, pfa, pfb;

    always_comb begin
        d_fafb  = 33'(fa_reg) - 33'(fb_reg);
        d_fbfa  = 33'(fb_reg) - 33'(fa_reg);
        d_fafc  = 33'(fa_reg) - 33'(fc_reg);
        d_fcfa  = 33'(fc_reg) - 33'(fa_reg);
        d_fbfc  = 33'(fb_reg) - 33'(fc_reg);
        d_fcfb  = 33'(fc_reg) - 33'(fb_reg);
        d_ba    = 33'(b_reg) - 33'(a_reg);
        d_bc    = 33'(b_reg) - 33'(c_reg);
        d_cd    = 33'(c_reg) - 33'(d_reg);
        d_sb    = 33'(scand_reg) - 33'(b_reg);
        q_mul   = brf_pkg::q16_sat(prod);
        acc_sum = acc_reg + 34'(q_mul);
        sum_ab  = 33'(a_reg) + 33'(b_reg);
        mid     = (sum_ab[32] && sum_ab[0]) ? 32'((sum_ab + 33'sd1) >>> 1) : 32'(sum_ab >>> 1);
        q4      = 35'(a_reg) * 35'sd3 + 35'(b_reg);
        s4      = 35'(scand_reg) <<< 2;
        between = (s4 > q4 && scand_reg < b_reg) || (s4 < q4 && scand_reg > b_reg);
        span_mag = brf_pkg::mag33(flag_reg ? d_bc : d_cd);
        sb2     = {brf_pkg::mag33(d_sb), 1'b0};
        bis     = !between || (sb2 >= {1'b0, span_mag})
                  || ({13'd0, span_mag, 16'd0} < tol2_reg);
        fuzzy_ac = brf_pkg::mag33(d_fafc) <= {2'b0, eps_reg};
        fuzzy_bc = brf_pkg::mag33(d_fbfc) <= {2'b0, eps_reg};
        conv_b  = (brf_pkg::mag33(33'(fb_reg)) <= {2'b0, eps_reg})
                  || ({13'd0, brf_pkg::mag33(d_ba), 16'd0} < tol2_reg);
        fuzzy_s = brf_pkg::mag33(33'(fs_reg)) <= {2'b0, eps_reg};
    end

    // bracket load for start and update for value, then ordering by |f|
    always_comb begin
        if (s_tuser[0] == brf_pkg::FUNC_START) begin
            opp_in = (in_fa < 0 && in_fb > 0) || (in_fa > 0 && in_fb < 0);
            pa = in_a; pb = in_b; pfa = in_fa; pfb = in_fb;
        end else begin
            opp_in = (fa_reg < 0 && in_fv > 0) || (fa_reg > 0 && in_fv < 0);
            if (opp_in) begin
                pa = a_reg; pfa = fa_reg; pb = probe_reg; pfb = in_fv;
            end else begin
                pa = probe_reg; pfa = in_fv; pb = b_reg; pfb = fb_reg;
            end
        end
        swap = brf_pkg::mag33(33'(pfa)) < brf_pkg::mag33(33'(pfb));
    end

    // shared unit operand selection
    always_comb begin
        dreq.start = (state_reg == S_DIV);
        dreq.num   = fb_reg;
        dreq.den   = d_fbfa;
        if (interp_reg) begin
            case (term_reg)
                2'd0: begin
                    dreq.num = phase_reg ? fc_reg : fb_reg;
                    dreq.den = phase_reg ? d_fafc : d_fafb;
                end
                2'd1: begin
                    dreq.num = phase_reg ? fc_reg : fa_reg;
                    dreq.den = phase_reg ? d_fbfc : d_fbfa;
                end
                default: begin
                    dreq.num = phase_reg ? fb_reg : fa_reg;
                    dreq.den = phase_reg ? d_fcfb : d_fcfa;
                end
            endcase
        end
        mul_en = (state_reg == S_MUL) || (state_reg == S_TOL);
        if (state_reg == S_TOL) begin
            mul_x = {1'b0, tol_reg};
            mul_y = {1'b0, tol_reg};
        end else if (!interp_reg) begin
            mul_x = divq_reg;
            mul_y = brf_pkg::sat35(35'(d_ba));
        end else if (phase_reg) begin
            mul_x = mtmp_reg;
            mul_y = divq_reg;
        end else begin
            case (term_reg)
                2'd0:    mul_x = a_reg;
                2'd1:    mul_x = b_reg;
                default: mul_x = c_reg;
            endcase
            mul_y = divq_reg;
        end
    end

    // step sequencer
    always_comb begin
        state_next = state_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        fa_next = fa_reg; fb_next = fb_reg; fc_next = fc_reg;
        probe_next = probe_reg; fs_next = fs_reg;
        flag_next = flag_reg; srch_next = srch_reg; vmode_next = vmode_reg;
        interp_next = interp_reg; term_next = term_reg; phase_next = phase_reg;
        divq_next = divq_reg; mtmp_next = mtmp_reg; scand_next = scand_reg;
        acc_next = acc_reg; tol2_next = tol2_reg;
        ost_next = ost_reg; opt_next = opt_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser[0] == brf_pkg::FUNC_START) begin
                        if (!opp_in) begin
                            srch_next  = 1'b0;
                            ost_next   = brf_pkg::ST_NO_BRACKET;
                            opt_next   = '0;
                            state_next = S_OUT;
                        end else begin
                            a_next  = swap ? pb : pa;
                            b_next  = swap ? pa : pb;
                            fa_next = swap ? pfb : pfa;
                            fb_next = swap ? pfa : pfb;
                            c_next  = swap ? pb : pa;
                            fc_next = swap ? pfb : pfa;
                            flag_next  = 1'b1;
                            vmode_next = 1'b0;
                            state_next = S_TOL;
                        end
                    end else if (!srch_reg) begin
                        ost_next   = brf_pkg::ST_NO_SEARCH;
                        opt_next   = '0;
                        state_next = S_OUT;
                    end else begin
                        d_next  = c_reg;
                        c_next  = b_reg;
                        fc_next = fb_reg;
                        a_next  = swap ? pb : pa;
                        b_next  = swap ? pa : pb;
                        fa_next = swap ? pfb : pfa;
                        fb_next = swap ? pfa : pfb;
                        fs_next = in_fv;
                        vmode_next = 1'b1;
                        state_next = S_TOL;
                    end
                end
            end
            S_TOL: state_next = S_TOLW;
            S_TOLW: begin
                tol2_next  = prod[61:0];
                state_next = S_CONV;
            end
            S_CONV: begin
                interp_next = !fuzzy_ac && !fuzzy_bc;
                term_next   = 2'd0;
                phase_next  = 1'b0;
                acc_next    = '0;
                state_next  = S_DIV;
                if (vmode_reg && conv_b) begin
                    srch_next  = 1'b0;
                    ost_next   = brf_pkg::ST_ROOT;
                    opt_next   = b_reg;
                    state_next = S_OUT;
                end else if (vmode_reg && fuzzy_s) begin
                    srch_next  = 1'b0;
                    ost_next   = brf_pkg::ST_ROOT;
                    opt_next   = probe_reg;
                    state_next = S_OUT;
                end
            end
            S_DIV: state_next = S_DIVW;
            S_DIVW: begin
                if (drsp.done) begin
                    divq_next  = drsp.quot;
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_MULW;
            S_MULW: begin
                if (!interp_reg) begin
                    scand_next = brf_pkg::sat35(35'(b_reg) - 35'(q_mul));
                    state_next = S_SEL;
                end else if (!phase_reg) begin
                    mtmp_next  = q_mul;
                    phase_next = 1'b1;
                    state_next = S_DIV;
                end else if (term_reg == 2'd2) begin
                    scand_next = brf_pkg::sat35(35'(acc_sum));
                    state_next = S_SEL;
                end else begin
                    acc_next   = acc_sum;
                    term_next  = term_reg + 2'd1;
                    phase_next = 1'b0;
                    state_next = S_DIV;
                end
            end
            S_SEL: begin
                probe_next = bis ? mid : scand_reg;
                flag_next  = bis;
                srch_next  = 1'b1;
                ost_next   = brf_pkg::ST_EVAL;
                opt_next   = bis ? mid : scand_reg;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            a_reg <= '0; b_reg <= '0; c_reg <= '0; d_reg <= '0;
            fa_reg <= '0; fb_reg <= '0; fc_reg <= '0;
            probe_reg <= '0;
            flag_reg  <= 1'b1;
            srch_reg  <= 1'b0;
            tol_reg   <= 31'd1;
            eps_reg   <= 31'd1;
        end else begin
            state_reg <= state_next;
            a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
            fa_reg <= fa_next; fb_reg <= fb_next; fc_reg <= fc_next;
            probe_reg <= probe_next;
            flag_reg  <= flag_next;
            srch_reg  <= srch_next;
            if (cfg_valid) begin
                if (cfg_addr == brf_pkg::CFG_TOLERANCE) begin
                    tol_reg <= cfg_data;
                end else begin
                    eps_reg <= cfg_data;
                end
            end
        end
        fs_reg <= fs_next; vmode_reg <= vmode_next; interp_reg <= interp_next;
        term_reg <= term_next; phase_reg <= phase_next;
        divq_reg <= divq_next; mtmp_reg <= mtmp_next; scand_reg <= scand_next;
        acc_reg <= acc_next; tol2_reg <= tol2_next;
        ost_reg <= ost_next; opt_reg <= opt_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = opt_reg;
    assign m_tuser   = ost_reg;

endmodule

/* sv/brf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_div
// Restoring radix-2 divider for Q16.16 quotients (num * 2^16) / den,
// truncated toward zero, saturating, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brf_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  brf_pkg::div_req_t req,
    output brf_pkg::div_rsp_t rsp
);

    localparam int DivSteps = 48;
    localparam int CntW     = $clog2(DivSteps);

    logic              busy_reg;
    logic [CntW-1:0]   cnt_reg;
    logic [32:0]       rem_reg;
    logic [47:0]       dvd_reg;
    logic [47:0]       quo_reg;
    logic [32:0]       dmag_reg;
    logic              neg_reg;
    logic              done_reg;
    logic signed [31:0] quot_reg;

    logic [33:0] rem_sh;
    logic        ge;
    logic [33:0] rem_sub;
    logic [47:0] quo_new;
    logic [31:0] nmag;
    logic signed [31:0] fin;

    // one restoring step
    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[47]};
        ge      = rem_sh >= {1'b0, dmag_reg};
        rem_sub = ge ? (rem_sh - {1'b0, dmag_reg}) : rem_sh;
        quo_new = {quo_reg[46:0], ge};
        nmag    = req.num[31] ? 32'(-req.num) : 32'(req.num);
        if (neg_reg) begin
            fin = (quo_new > 48'h0000_8000_0000) ? brf_pkg::Q_MIN : (~quo_new[31:0] + 32'd1);
        end else begin
            fin = (quo_new > 48'h0000_7FFF_FFFF) ? brf_pkg::Q_MAX : quo_new[31:0];
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                if (req.den == 33'sd0) begin
                    done_reg <= 1'b1;
                    if (req.num > 32'sd0) begin
                        quot_reg <= brf_pkg::Q_MAX;
                    end else if (req.num < 32'sd0) begin
                        quot_reg <= brf_pkg::Q_MIN;
                    end else begin
                        quot_reg <= '0;
                    end
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    dvd_reg  <= {nmag, 16'd0};
                    dmag_reg <= brf_pkg::mag33(req.den);
                    neg_reg  <= req.num[31] ^ req.den[32];
                end
            end else if (busy_reg) begin
                rem_reg <= rem_sub[32:0];
                dvd_reg <= {dvd_reg[46:0], 1'b0};
                quo_reg <= quo_new;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DivSteps - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    quot_reg <= fin;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

/* sv/brf_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_mul
// Shared 32x32 signed multiplier with a registered full product.
// ----------------------------------------------------------------------------
module brf_mul (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] op_x,
    input  logic signed [31:0] op_y,
    output logic signed [63:0] prod
);

    logic signed [63:0] prod_reg;

    // product register
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 64'(op_x) * 64'(op_y);
        end
    end

    assign prod = prod_reg;

endmodule

/* sv/brf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks for the Brent root finder step, bound to the top level.
// ----------------------------------------------------------------------------
module brf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // an accepted transaction makes the block busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a transaction is in progress");

    // never takes input while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // error and idle results carry a zero point
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == brf_pkg::ST_NO_BRACKET || m_tuser == brf_pkg::ST_NO_SEARCH)
        |-> m_tdata == 32'd0)
        else $error("nonzero point on error status");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind brent_root_finder_step brf_checker u_brf_checker (.*);

/* bench/brf_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_result_checker
// Watches the configuration, input and result channels of the Brent root
// finder step. It keeps its own copy of the search state, works out the
// expected result of each accepted input transaction and compares every
// result transaction with the oldest expected one.
// ----------------------------------------------------------------------------
module brf_result_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_addr,
    input  logic [30:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [159:0] s_tdata,  // start_a, start_b, start_fa, start_fb, probe_value
    input  logic [0:0]   s_tuser,  // func
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,  // point
    input  logic [1:0]   m_tuser,  // status
    output int           fail_count
);

    localparam longint ONE_Q  = 65536;
    localparam longint MAX_32 = 64'sd2147483647;
    localparam longint MIN_32 = -64'sd2147483648;

    typedef struct {
        brf_pkg::status_t status;
        logic [31:0]      point;
    } step_result_t;

    step_result_t pending_results[$];
    int           mismatch_count = 0;

    // predicted search state and registers
    longint tol_q, eps_q;
    longint br_a, br_b, old_c, old_d;
    longint f_a, f_b, f_c;
    longint probe_x;
    bit     bisected, active;

    function automatic longint clamp32(longint v);
        if (v > MAX_32) return MAX_32;
        if (v < MIN_32) return MIN_32;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint fx_mul(longint x, longint y);
        return clamp32((clamp32(x) * clamp32(y)) / ONE_Q);
    endfunction

    function automatic longint fx_div(longint n, longint d);
        if (d == 0) begin
            if (n > 0) return MAX_32;
            if (n < 0) return MIN_32;
            return 0;
        end
        return clamp32((n * ONE_Q) / d);
    endfunction

    function automatic bit near(longint x, longint y);
        return mag(x - y) <= eps_q;
    endfunction

    function automatic bit under_tol(longint diff);
        return mag(diff) * ONE_Q < tol_q * tol_q;
    endfunction

    function automatic bit signs_differ(longint x, longint y);
        return (x < 0 && y > 0) || (x > 0 && y < 0);
    endfunction

    // keep the end with the smaller value magnitude as b
    function automatic void swap_if_needed();
        longint t;
        if (mag(f_a) < mag(f_b)) begin
            t = br_a; br_a = br_b; br_b = t;
            t = f_a;  f_a = f_b;   f_b = t;
        end
    endfunction

    // interpolation or secant, then the bisection safeguard
    function automatic void choose_probe();
        longint s, t1, t2, t3, q4, span;
        bit between, use_mid;
        if (!near(f_a, f_c) && !near(f_b, f_c)) begin
            t1 = fx_mul(fx_mul(br_a, fx_div(f_b, f_a - f_b)), fx_div(f_c, f_a - f_c));
            t2 = fx_mul(fx_mul(br_b, fx_div(f_a, f_b - f_a)), fx_div(f_c, f_b - f_c));
            t3 = fx_mul(fx_mul(old_c, fx_div(f_a, f_c - f_a)), fx_div(f_b, f_c - f_b));
            s = clamp32(t1 + t2 + t3);
        end else begin
            s = clamp32(br_b - fx_mul(fx_div(f_b, f_b - f_a), clamp32(br_b - br_a)));
        end
        q4 = 3 * br_a + br_b;
        between = (4 * s > q4 && s < br_b) || (4 * s < q4 && s > br_b);
        span = bisected ? (br_b - old_c) : (old_c - old_d);
        use_mid = !between || 2 * mag(s - br_b) >= mag(span) || under_tol(span);
        if (use_mid) s = (br_a + br_b) / 2;
        bisected = use_mid;
        probe_x = s;
    endfunction

    function automatic step_result_t predict_step(bit func, longint a0, longint b0,
                                                  longint fa0, longint fb0, longint fs);
        step_result_t r;
        longint s;
        r.status = brf_pkg::ST_NO_SEARCH;
        r.point  = '0;
        if (func == brf_pkg::FUNC_START) begin
            if (!signs_differ(fa0, fb0)) begin
                active   = 1'b0;
                r.status = brf_pkg::ST_NO_BRACKET;
            end else begin
                br_a = a0; br_b = b0; f_a = fa0; f_b = fb0;
                swap_if_needed();
                old_c    = br_a;
                f_c      = f_a;
                bisected = 1'b1;
                choose_probe();
                active   = 1'b1;
                r.status = brf_pkg::ST_EVAL;
                r.point  = probe_x[31:0];
            end
        end else if (active) begin
            s     = probe_x;
            old_d = old_c;
            old_c = br_b;
            f_c   = f_b;
            if (signs_differ(f_a, fs)) begin
                br_b = s; f_b = fs;
            end else begin
                br_a = s; f_a = fs;
            end
            swap_if_needed();
            if (near(f_b, 0) || under_tol(br_b - br_a)) begin
                active   = 1'b0;
                r.status = brf_pkg::ST_ROOT;
                r.point  = br_b[31:0];
            end else if (near(fs, 0)) begin
                active   = 1'b0;
                r.status = brf_pkg::ST_ROOT;
                r.point  = s[31:0];
            end else begin
                choose_probe();
                r.status = brf_pkg::ST_EVAL;
                r.point  = probe_x[31:0];
            end
        end
        return r;
    endfunction

    // follow every transaction on the three channels
    always @(posedge aclk) begin
        step_result_t want;
        if (!aresetn) begin
            tol_q = 1; eps_q = 1;
            br_a = 0; br_b = 0; old_c = 0; old_d = 0;
            f_a = 0; f_b = 0; f_c = 0; probe_x = 0;
            bisected = 1'b1; active = 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_addr == brf_pkg::CFG_TOLERANCE) tol_q = longint'(cfg_data);
                else eps_q = longint'(cfg_data);
            end
            if (s_tvalid && s_tready) begin
                pending_results.push_back(predict_step(s_tuser[0],
                    longint'($signed(s_tdata[31:0])),   longint'($signed(s_tdata[63:32])),
                    longint'($signed(s_tdata[95:64])),  longint'($signed(s_tdata[127:96])),
                    longint'($signed(s_tdata[159:128]))));
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no expected result: status %0d point %h",
                           m_tuser, m_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata !== want.point) begin
                        $error("point: expected %h, actual %h", want.point, m_tdata);
                        mismatch_count++;
                    end
                end
            end
        end
        fail_count <= mismatch_count + pending_results.size();
    end

endmodule

/* bench/brent_root_finder_step_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brent_root_finder_step_tb
// Drives the Brent root finder step with directed corner items and then with
// root searches on random functions, answering most probe points with the
// function value, under several tolerance settings and random stalls on
// both channels. Results are checked by brf_result_checker.
// ----------------------------------------------------------------------------
module brent_root_finder_step_tb;

    localparam longint MAX_32 = 64'sd2147483647;
    localparam longint MIN_32 = -64'sd2147483648;
    localparam int     ITEM_GOAL = 600;
    localparam int     STEP_CAP = 60;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_addr = 1'b0;
    logic [30:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;  // start_a, start_b, start_fa, start_fb, probe_value
    logic [0:0]   s_tuser = '0;  // func
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;       // point
    logic [1:0]   m_tuser;       // status
    int           fail_count;

    int               sent_count = 0;
    int               got_count = 0;
    bit               offering = 1'b0;
    bit               calm = 1'b0;
    logic             hold_rx = 1'b0;
    int               rx_wait = 0;
    brf_pkg::status_t last_status = brf_pkg::ST_NO_SEARCH;
    longint           last_point = 0;

    // current test function: slope times distance to the root, plus a cubic term when cubic is set
    longint root_x;
    longint slope;
    bit     cubic;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    brent_root_finder_step u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    brf_result_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count)
    );

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint any32();
        return longint'($signed($urandom()));
    endfunction

    function automatic longint clip32(longint v);
        if (v > MAX_32) return MAX_32;
        if (v < MIN_32) return MIN_32;
        return v;
    endfunction

    function automatic longint eval_f(longint x);
        longint d;
        d = x - root_x;
        if (cubic) return clip32(d * slope + ((d * d) >>> 20) * d / 65536);
        return clip32(d * slope);
    endfunction

    // result side: random stalls, long hold while hold_rx is set
    always @(posedge aclk) begin
        int g;
        if (m_tvalid && m_tready) begin
            got_count   <= got_count + 1;
            last_status <= brf_pkg::status_t'(m_tuser);
            last_point  <= longint'($signed(m_tdata));
        end
        if (hold_rx) begin
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait  <= rx_wait - 1;
        end else if (m_tvalid && m_tready) begin
            g = pick_gap();
            if (g > 0) begin
                m_tready <= 1'b0;
                rx_wait  <= g - 1;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(bit func, longint a, longint b, longint fa, longint fb,
                             longint fs);
        int g;
        g = pick_gap();
        if (g > 0) begin
            if (offering) s_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tuser  <= func;
        s_tdata  <= {fs[31:0], fb[31:0], fa[31:0], b[31:0], a[31:0]};
        s_tvalid <= 1'b1;
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    task automatic stop_offering();
        if (offering) s_tvalid <= 1'b0;
        offering = 1'b0;
    endtask

    task automatic drain();
        stop_offering();
        while (got_count != sent_count) @(posedge aclk);
        @(posedge aclk);
    endtask

    // one item, then wait for its answer
    task automatic exchange(bit func, longint a, longint b, longint fa, longint fb,
                            longint fs);
        send_item(func, a, b, fa, fb, fs);
        drain();
    endtask

    task automatic write_reg(logic idx, logic [30:0] val);
        cfg_addr  <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_tolerances(logic [30:0] tol, logic [30:0] eps);
        drain();
        repeat (8) @(posedge aclk);
        write_reg(brf_pkg::CFG_TOLERANCE, tol);
        write_reg(brf_pkg::CFG_ZERO_EPSILON, eps);
    endtask

    // full search on a random function, sometimes abandoned or fed a wrong value
    task automatic run_search();
        longint a, b, t;
        int steps;
        bit wide;
        wide  = ($urandom_range(0, 7) == 0);
        slope = $urandom_range(1, 8);
        if ($urandom_range(0, 1)) slope = -slope;
        cubic = !wide && $urandom_range(0, 1);
        if (wide) begin
            root_x = any32() / 2;
            a = MIN_32 + $urandom_range(0, 1000);
            b = MAX_32 - $urandom_range(0, 1000);
        end else begin
            root_x = longint'($urandom_range(0, 2097152)) - 1048576;
            a = root_x - $urandom_range(1, 262144);
            b = root_x + $urandom_range(1, 262144);
        end
        if ($urandom_range(0, 1)) begin
            t = a; a = b; b = t;
        end
        exchange(brf_pkg::FUNC_START, a, b, eval_f(a), eval_f(b), any32());
        steps = 0;
        while (last_status == brf_pkg::ST_EVAL && steps < STEP_CAP) begin
            if ($urandom_range(0, 49) == 0) break;
            if ($urandom_range(0, 39) == 0)
                exchange(1'b1, any32(), any32(), any32(), any32(), any32());
            else
                exchange(1'b1, any32(), any32(), any32(), any32(), eval_f(last_point));
            steps++;
        end
    endtask

    task automatic run_phase(int goal);
        while (sent_count < goal) begin
            if ($urandom_range(0, 9) == 0)
                exchange($urandom_range(0, 1), any32(), any32(), any32(), any32(), any32());
            else
                run_search();
        end
    endtask

    // timeout
    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners under reset settings
        exchange(1'b1, 0, 0, 0, 0, MAX_32);
        exchange(brf_pkg::FUNC_START, 0, 65536, 0, 5, 0);
        exchange(brf_pkg::FUNC_START, 0, 65536, MAX_32, MAX_32, 0);
        exchange(brf_pkg::FUNC_START, MIN_32, MAX_32, MIN_32, MIN_32, MIN_32);
        exchange(brf_pkg::FUNC_START, MIN_32, MAX_32, MIN_32, MAX_32, 0);
        exchange(1'b1, 0, 0, 0, 0, MAX_32);
        exchange(1'b1, 0, 0, 0, 0, MIN_32);
        exchange(1'b1, 0, 0, 0, 0, 0);
        exchange(1'b1, 0, 0, 0, 0, 1);
        exchange(brf_pkg::FUNC_START, MAX_32, MIN_32, 1, -1, MAX_32);
        exchange(1'b1, MAX_32, MAX_32, MAX_32, MAX_32, -1);
        exchange(brf_pkg::FUNC_START, -65536, 65536, -3, 7, 0);
        exchange(brf_pkg::FUNC_START, 65536, -65536, MAX_32, MIN_32, 0);
        exchange(1'b1, -1, -1, -1, -1, 2);
        exchange(brf_pkg::FUNC_START, 0, 1, -1, 1, 0);
        exchange(1'b1, 0, 0, 0, 0, 5);
        exchange(brf_pkg::FUNC_START, 5, 5, 1, 1, 0);
        exchange(1'b1, 0, 0, 0, 0, 0);
        exchange(brf_pkg::FUNC_START, 0, 0, 1, -1, 0);

        // receiver holds off while the sender keeps offering
        exchange(brf_pkg::FUNC_START, -65536, 65536, -65536, 65536, 0);
        fork
            begin
                hold_rx <= 1'b1;
                repeat (2000) @(posedge aclk);
                hold_rx <= 1'b0;
            end
            begin
                repeat (10) send_item(1'b1, any32(), any32(), any32(), any32(), any32());
            end
        join
        drain();

        run_phase(150);
        set_tolerances(31'd0, 31'd0);
        calm = 1'b1;
        run_phase(260);
        calm = 1'b0;
        set_tolerances(31'h7FFF_FFFF, 31'h7FFF_FFFF);
        run_phase(300);
        set_tolerances(31'd64, 31'd16);
        run_phase(420);
        set_tolerances(31'd16, 31'd4096);
        run_phase(500);
        set_tolerances(31'($urandom_range(0, 512)), 31'($urandom_range(0, 64)));
        run_phase(ITEM_GOAL);

        drain();
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/brf_pkg.sv
sv/brf_div.sv
sv/brf_mul.sv
sv/brent_root_finder_step.sv
sv/brf_checker.sv
bench/brf_result_checker.sv
bench/brent_root_finder_step_tb.sv
